/* rtl/core/b64se_pkg.sv */
// shared constants, register indexes and the sextet to ascii mapping
// for the base64 stream encoder; no dependencies
package b64se_pkg;

  localparam int unsigned LineLimit = 64;
  localparam int unsigned CharBufDepth = 5;

  localparam logic [7:0] CharLineFeed = 8'h0a;
  localparam logic [7:0] CharPad      = 8'h3d;
  localparam logic [7:0] CharPlus     = 8'h2b;
  localparam logic [7:0] CharSlash    = 8'h2f;
  localparam logic [7:0] CharMinus    = 8'h2d;
  localparam logic [7:0] CharUnder    = 8'h5f;
  localparam logic [7:0] CharUpperA   = 8'h41;
  localparam logic [7:0] CharLowerA   = 8'h61;
  localparam logic [7:0] CharZero     = 8'h30;

  typedef enum logic [0:0] {
    RegLineBreak = 1'b0,
    RegAlphabet  = 1'b1
  } reg_idx_e;

  // map one sextet to its character, url-safe when url is set
  function automatic logic [7:0] sextet_char(logic [5:0] v, logic url);
    logic [7:0] c;
    c = {2'b00, v};
    if (v < 6'd26) begin
      c = CharUpperA + {2'b00, v};
    end else if (v < 6'd52) begin
      c = CharLowerA + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = CharZero + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = url ? CharMinus : CharPlus;
    end else begin
      c = url ? CharUnder : CharSlash;
    end
    return c;
  endfunction

endpackage

/* rtl/core/base64_stream_encoder.sv */
// base64 stream encoder top level: byte gathering, group encode, character output
// depends on b64se_pkg
//
// channel  direction  handshake                 payload
// in       sink       in_valid_i / in_ready_o   data_byte_i, is_last_i
// out      source     out_valid_o / out_ready_i out_char_o, out_last_o
// cfg      sink       cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// a byte that only waits is taken even while characters drain
// a group is encoded in the accepting cycle into a five entry character buffer
// the buffer sends one character a cycle while out_ready_i is high: four per group,
// five with a line feed, so the output sets the rate at which groups are taken
// reset clears the pending bytes, line count and registers and empties the buffer
// a stall on the output holds the buffer; bytes completing a group then wait
module base64_stream_encoder
  import b64se_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  localparam int unsigned IdxW = $clog2(CharBufDepth);
  localparam logic [IdxW-1:0] IdxEnd = IdxW'(CharBufDepth - 1);
  localparam logic [6:0] LineLim = 7'(LineLimit);

  logic        line_break_q, alphabet_q;
  logic [15:0] pend_q, pend_d;
  logic [1:0]  pcnt_q, pcnt_d;
  logic [6:0]  line_q, line_d;

  logic [7:0]      cbuf_q [CharBufDepth];
  logic [7:0]      cbuf_d [CharBufDepth];
  logic [IdxW-1:0] idx_q, idx_d;
  logic            busy_q, busy_d;
  logic            glast_q, glast_d;

  logic        accept, group, drain_done, line_full;
  logic [1:0]  n_bytes;
  logic [23:0] triple;
  logic [6:0]  line_base;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_break_q <= 1'b0;
      alphabet_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegLineBreak: line_break_q <= cfg_wdata_i;
        RegAlphabet:  alphabet_q   <= cfg_wdata_i;
        default:      line_break_q <= line_break_q;
      endcase
    end
  end

  assign drain_done  = busy_q && out_ready_i && (idx_q == IdxEnd);
  assign in_ready_o  = !busy_q || drain_done || ((pcnt_q != 2'd2) && !is_last_i);
  assign accept      = in_valid_i && in_ready_o;
  assign group       = accept && ((pcnt_q == 2'd2) || is_last_i);
  assign n_bytes     = pcnt_q;
  assign line_full   = (line_q >= LineLim);
  assign line_base   = line_full ? 7'd0 : line_q;

  always_comb begin
    case (n_bytes)
      2'd0:    triple = {data_byte_i, 16'h0000};
      2'd1:    triple = {pend_q[7:0], data_byte_i, 8'h00};
      default: triple = {pend_q, data_byte_i};
    endcase
  end

  always_comb begin
    pend_d  = pend_q;
    pcnt_d  = pcnt_q;
    line_d  = line_q;
    cbuf_d  = cbuf_q;
    idx_d   = idx_q;
    busy_d  = busy_q;
    glast_d = glast_q;

    // output side advances first, a new group overrides below
    if (busy_q && out_ready_i) begin
      if (idx_q == IdxEnd) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end

    if (accept) begin
      if (group) begin
        cbuf_d[0] = CharLineFeed;
        cbuf_d[1] = sextet_char(triple[23:18], alphabet_q);
        cbuf_d[2] = sextet_char(triple[17:12], alphabet_q);
        cbuf_d[3] = (n_bytes == 2'd0) ? CharPad : sextet_char(triple[11:6], alphabet_q);
        cbuf_d[4] = (n_bytes != 2'd2) ? CharPad : sextet_char(triple[5:0], alphabet_q);
        idx_d     = (line_full && line_break_q) ? IdxW'(0) : IdxW'(1);
        busy_d    = 1'b1;
        glast_d   = is_last_i;
        pend_d    = 16'h0000;
        pcnt_d    = 2'd0;
        line_d    = is_last_i ? 7'd0 : line_base + 7'd4;
      end else begin
        pend_d = {pend_q[7:0], data_byte_i};
        pcnt_d = pcnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 16'h0000;
      pcnt_q  <= 2'd0;
      line_q  <= 7'd0;
      idx_q   <= '0;
      busy_q  <= 1'b0;
      glast_q <= 1'b0;
    end else begin
      pend_q  <= pend_d;
      pcnt_q  <= pcnt_d;
      line_q  <= line_d;
      idx_q   <= idx_d;
      busy_q  <= busy_d;
      glast_q <= glast_d;
    end
  end

  // character buffer, payload only
  always_ff @(posedge clk_i) begin
    cbuf_q <= cbuf_d;
  end

  assign out_valid_o = busy_q;
  assign out_char_o  = cbuf_q[idx_q];
  assign out_last_o  = glast_q && (idx_q == IdxEnd);

endmodule
